// File: src/positional_sequence_store_core_defines.svh
// ----------------------------------------------------------------------------
// Positional sequence store assertion macros
// Clocked assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PSS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/psstore_pkg.sv
// ----------------------------------------------------------------------------
// Positional sequence store package
// Shared widths, codes and the command that steers the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package psstore_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 7;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_DUMP   = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;
	localparam logic [1:0] STATUS_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [CNT_W-1:0]      pos;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]      last_idx;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} ctrl_state_t;

endpackage

`default_nettype wire

// File: src/psstore_cell.sv
// ----------------------------------------------------------------------------
// Positional sequence store cell
// Holds one element; on command loads the new value, shifts from its left or right neighbor, or takes the head.
// ----------------------------------------------------------------------------
`default_nettype none

module psstore_cell #(
	parameter int INDEX = 0
) (
	input  wire logic                                  clk,
	input  wire psstore_pkg::cell_cmd_t                cmd,
	input  wire logic signed [psstore_pkg::DATA_W-1:0] left_data,
	input  wire logic signed [psstore_pkg::DATA_W-1:0] right_data,
	input  wire logic signed [psstore_pkg::DATA_W-1:0] head_data,
	output logic signed [psstore_pkg::DATA_W-1:0]      data_q
);

	localparam logic [psstore_pkg::CNT_W-1:0] IDX = psstore_pkg::CNT_W'(INDEX);

	logic signed [psstore_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			psstore_pkg::CELL_INSERT: begin
				if (IDX == cmd.pos) begin
					data_d = cmd.value;
				end else if (IDX > cmd.pos) begin
					data_d = left_data;
				end
			end
			psstore_pkg::CELL_DELETE: begin
				if (IDX >= cmd.pos) begin
					data_d = right_data;
				end
			end
			psstore_pkg::CELL_ROTATE: begin
				if (IDX == cmd.last_idx) begin
					data_d = head_data;
				end else begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

`default_nettype wire

// File: src/psstore_ctrl.sv
// ----------------------------------------------------------------------------
// Positional sequence store controller
// Decodes transactions, keeps the count, steers the cells, registers results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_sequence_store_core_defines.svh"

module psstore_ctrl #(
	parameter int CAPACITY = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            kind,
	input  wire logic [psstore_pkg::CNT_W-1:0]         position,
	input  wire logic signed [psstore_pkg::DATA_W-1:0] value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [1:0]                                 status,
	output logic signed [psstore_pkg::DATA_W-1:0]      element,
	output logic [psstore_pkg::CNT_W-1:0]              count,
	output logic                                       last,
	input  wire logic signed [psstore_pkg::DATA_W-1:0] head_data,
	output psstore_pkg::cell_cmd_t                     cmd
);

	localparam logic [psstore_pkg::CNT_W-1:0] CAP = psstore_pkg::CNT_W'(CAPACITY);

	psstore_pkg::ctrl_state_t state_q, state_d;
	logic [psstore_pkg::CNT_W-1:0] count_q, count_d;
	logic [psstore_pkg::CNT_W-1:0] idx_q, idx_d;
	logic                          out_valid_q;
	logic [1:0]                    status_q, status_d;
	logic signed [psstore_pkg::DATA_W-1:0] element_q, element_d;
	logic [psstore_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                          last_q, last_d;
	logic                          slot_free;
	logic                          accept;
	logic                          load;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		in_ready  = (state_q == psstore_pkg::ST_IDLE) && slot_free;
		accept    = in_valid && in_ready;
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		load      = 1'b0;
		status_d  = psstore_pkg::STATUS_OK;
		element_d = '0;
		cnt_d     = count_q;
		last_d    = 1'b1;
		cmd.op       = psstore_pkg::CELL_HOLD;
		cmd.pos      = (position > count_q) ? count_q : position;
		cmd.value    = value;
		cmd.last_idx = count_q - 1'b1;
		case (state_q)
			psstore_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind)
						psstore_pkg::KIND_INSERT: begin
							load = 1'b1;
							if (count_q == CAP) begin
								status_d = psstore_pkg::STATUS_FULL;
							end else begin
								cmd.op  = psstore_pkg::CELL_INSERT;
								count_d = count_q + 1'b1;
								cnt_d   = count_d;
							end
						end
						psstore_pkg::KIND_DELETE: begin
							load = 1'b1;
							if (position >= count_q) begin
								status_d = psstore_pkg::STATUS_RANGE;
							end else begin
								cmd.op  = psstore_pkg::CELL_DELETE;
								count_d = count_q - 1'b1;
								cnt_d   = count_d;
							end
						end
						psstore_pkg::KIND_DUMP: begin
							if (count_q == '0) begin
								load     = 1'b1;
								status_d = psstore_pkg::STATUS_EMPTY;
							end else begin
								state_d = psstore_pkg::ST_DUMP;
								idx_d   = '0;
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			psstore_pkg::ST_DUMP: begin
				if (slot_free) begin
					load      = 1'b1;
					element_d = head_data;
					last_d    = (idx_q == count_q - 1'b1);
					cmd.op    = psstore_pkg::CELL_ROTATE;
					idx_d     = idx_q + 1'b1;
					if (last_d) begin
						state_d = psstore_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = psstore_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psstore_pkg::ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= status_d;
			element_q <= element_d;
			cnt_q     <= cnt_d;
			last_q    <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign count     = cnt_q;
	assign last      = last_q;

	`PSS_ASSERT(a_count_cap, clk, arst_n, count_q <= CAP, "count above capacity")
	`PSS_ASSERT_IMPL(a_dump_nonempty, clk, arst_n, state_q == psstore_pkg::ST_DUMP, count_q != '0, "dump with empty store")
	`PSS_ASSERT_IMPL(a_dump_idx, clk, arst_n, state_q == psstore_pkg::ST_DUMP, idx_q < count_q, "dump index past end")
	`PSS_ASSERT_IMPL(a_insert_grow, clk, arst_n, accept && kind == psstore_pkg::KIND_INSERT && count_q != CAP, ##1 count_q == $past(count_q) + 1'b1, "insert did not grow count")

endmodule

`default_nettype wire

// File: src/positional_sequence_store_core.sv
// ----------------------------------------------------------------------------
// Positional sequence store core
// Ordered sequence of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries kind, position and value; the
// output channel (out_valid/out_ready) carries status, element, count, last.
// Insert and delete shift every cell at once and give one result with last
// set, registered in the cycle after the transaction is taken. A dump
// rotates the row one place per cycle, emitting one element per cycle while
// the output register is free; the state register first moves to dump and
// then the first element is registered. Insert and delete are taken one per
// cycle while the receiver keeps up; the next transaction after a dump is
// taken once the dump ends, set by the single output register and the
// one-step rotation of the row. Kind 3 is taken and dropped without a result.
// Reset clears the count and the output valid; cell contents are left as is.
// While a result waits on a stalled receiver, it holds and in_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_sequence_store_core #(
	parameter int CAPACITY = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            kind,
	input  wire logic [psstore_pkg::CNT_W-1:0]         position,
	input  wire logic signed [psstore_pkg::DATA_W-1:0] value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [1:0]                                 status,
	output logic signed [psstore_pkg::DATA_W-1:0]      element,
	output logic [psstore_pkg::CNT_W-1:0]              count,
	output logic                                       last
);

	psstore_pkg::cell_cmd_t cmd;
	logic signed [psstore_pkg::DATA_W-1:0] cell_data [CAPACITY];

	psstore_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.element   (element),
		.count     (count),
		.last      (last),
		.head_data (cell_data[0]),
		.cmd       (cmd)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [psstore_pkg::DATA_W-1:0] left_data;
		logic signed [psstore_pkg::DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = cmd.value;
		end else begin : g_mid_l
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_data = cell_data[i];
		end else begin : g_mid_r
			assign right_data = cell_data[i+1];
		end

		psstore_cell #(
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  (left_data),
			.right_data (right_data),
			.head_data  (cell_data[0]),
			.data_q     (cell_data[i])
		);
	end

endmodule

`default_nettype wire

// File: tb/sv/positional_sequence_store_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional sequence store core testbench
// Sends insert, delete and dump transactions through the valid/ready input,
// keeps its own copy of the sequence to work out every expected result, and
// checks each output transaction field by field in arrival order. Runs a
// directed opening and then random fill and drain sweeps under four idling
// patterns, letting all results drain between patterns.
// ----------------------------------------------------------------------------
module positional_sequence_store_core_test;

	localparam int CAPACITY = 64;
	localparam int RANDOM_PER_PHASE = 73;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]                            kind;
		logic [psstore_pkg::CNT_W-1:0]         position;
		logic signed [psstore_pkg::DATA_W-1:0] value;
	} seq_cmd_t;

	typedef struct packed {
		logic [1:0]                            status;
		logic signed [psstore_pkg::DATA_W-1:0] element;
		logic [psstore_pkg::CNT_W-1:0]         count;
		logic                                  last;
	} seq_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = psstore_pkg::KIND_INSERT;
	logic [psstore_pkg::CNT_W-1:0] position = '0;
	logic signed [psstore_pkg::DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [psstore_pkg::DATA_W-1:0] element;
	logic [psstore_pkg::CNT_W-1:0] count;
	logic last;

	seq_cmd_t queued_cmds[$];
	seq_result_t awaited_results[$];
	seq_cmd_t driven_cmd;

	logic signed [psstore_pkg::DATA_W-1:0] seq_mem [CAPACITY];
	int seq_len = 0;
	int planned_len = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;

	positional_sequence_store_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.element(element),
		.count(count),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic queue_cmd(input logic [1:0] k, input int p, input logic [31:0] v);
		seq_cmd_t c;
		c.kind = k;
		c.position = p[psstore_pkg::CNT_W-1:0];
		c.value = v;
		queued_cmds.push_back(c);
		case (k)
			psstore_pkg::KIND_INSERT: if (planned_len < CAPACITY) planned_len++;
			psstore_pkg::KIND_DELETE: if (p < planned_len) planned_len--;
			default: ;
		endcase
	endtask

	// Apply one accepted transaction to the local sequence and queue its results.
	task automatic run_sequence_op(input seq_cmd_t c);
		seq_result_t res;
		int i;
		int p;
		res = '0;
		res.last = 1'b1;
		p = c.position;
		case (c.kind)
			psstore_pkg::KIND_INSERT: begin
				if (seq_len >= CAPACITY) begin
					res.status = psstore_pkg::STATUS_FULL;
				end else begin
					if (p > seq_len)
						p = seq_len;
					for (i = seq_len; i > p; i--)
						seq_mem[i] = seq_mem[i-1];
					seq_mem[p] = c.value;
					seq_len++;
					res.status = psstore_pkg::STATUS_OK;
				end
				res.count = psstore_pkg::CNT_W'(seq_len);
				awaited_results.push_back(res);
			end
			psstore_pkg::KIND_DELETE: begin
				if (p >= seq_len) begin
					res.status = psstore_pkg::STATUS_RANGE;
				end else begin
					for (i = p; i < seq_len - 1; i++)
						seq_mem[i] = seq_mem[i+1];
					seq_len--;
					res.status = psstore_pkg::STATUS_OK;
				end
				res.count = psstore_pkg::CNT_W'(seq_len);
				awaited_results.push_back(res);
			end
			psstore_pkg::KIND_DUMP: begin
				if (seq_len == 0) begin
					res.status = psstore_pkg::STATUS_EMPTY;
					awaited_results.push_back(res);
				end else begin
					for (i = 0; i < seq_len; i++) begin
						res.status = psstore_pkg::STATUS_OK;
						res.element = seq_mem[i];
						res.count = psstore_pkg::CNT_W'(seq_len);
						res.last = (i == seq_len - 1);
						awaited_results.push_back(res);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= psstore_pkg::KIND_INSERT;
			position <= '0;
			value <= '0;
		end else begin
			if (in_valid && in_ready)
				run_sequence_op(driven_cmd);
			if (!in_valid || in_ready) begin
				if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_cmd = queued_cmds.pop_front();
					in_valid <= 1'b1;
					kind <= driven_cmd.kind;
					position <= driven_cmd.position;
					value <= driven_cmd.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		seq_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display({"%0t: unexpected transaction, expected none, actual status %0d",
					" element 'h%0h count %0d last %0d"},
					$time, status, element, count, last);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("element", want.element, element);
				compare_field("count", 32'(want.count), 32'(count));
				compare_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				awaited_results.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int idle_pcts [4];
		int stall_pcts [4];
		int ph;
		int n;
		int r;
		int p;
		logic [1:0] k;
		logic [31:0] v;
		bit filling;
		int full_hits;

		idle_pcts = '{0, 51, 0, 37};
		stall_pcts = '{0, 0, 51, 37};
		filling = 1'b1;
		full_hits = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			send_idle_pct = idle_pcts[ph];
			recv_stall_pct = stall_pcts[ph];
			if (ph == 0) begin
				queue_cmd(psstore_pkg::KIND_DUMP, 0, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 0, 32'h0);
				queue_cmd(KIND_UNUSED, 127, 32'hffff_ffff);
				queue_cmd(psstore_pkg::KIND_INSERT, 0, 32'h7fff_ffff);
				queue_cmd(psstore_pkg::KIND_INSERT, 127, 32'h8000_0000);
				queue_cmd(psstore_pkg::KIND_INSERT, 1, 32'h0);
				queue_cmd(psstore_pkg::KIND_INSERT, 64, 32'hffff_ffff);
				queue_cmd(psstore_pkg::KIND_INSERT, 0, 32'h1234_5678);
				queue_cmd(psstore_pkg::KIND_DUMP, 127, 32'hffff_ffff);
				queue_cmd(psstore_pkg::KIND_DELETE, 4, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 4, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 1, 32'hffff_ffff);
				queue_cmd(psstore_pkg::KIND_DUMP, 0, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 127, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 0, 32'h0);
				queue_cmd(KIND_UNUSED, 0, 32'h5555_aaaa);
				queue_cmd(psstore_pkg::KIND_DUMP, 0, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 0, 32'h0);
				queue_cmd(psstore_pkg::KIND_DELETE, 0, 32'h0);
				queue_cmd(psstore_pkg::KIND_DUMP, 64, 32'h0);
			end
			// alternate fill and drain sweeps so the store reaches full and drains to two or fewer
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				r = $urandom_range(99);
				if ($urandom_range(9) == 0) begin
					case ($urandom_range(3))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = 32'h0;
						default: v = 32'hffff_ffff;
					endcase
				end else begin
					v = $urandom;
				end
				if (filling)
					k = (r < 80) ? psstore_pkg::KIND_INSERT :
						(r < 88) ? psstore_pkg::KIND_DELETE :
						(r < 95) ? psstore_pkg::KIND_DUMP : KIND_UNUSED;
				else
					k = (r < 12) ? psstore_pkg::KIND_INSERT :
						(r < 80) ? psstore_pkg::KIND_DELETE :
						(r < 93) ? psstore_pkg::KIND_DUMP : KIND_UNUSED;
				if (filling && planned_len == CAPACITY) begin
					k = psstore_pkg::KIND_INSERT;
					full_hits++;
				end
				p = $urandom_range(127);
				if (k == psstore_pkg::KIND_INSERT && $urandom_range(99) < 85)
					p = $urandom_range(planned_len);
				if (k == psstore_pkg::KIND_DELETE && planned_len != 0 &&
						$urandom_range(99) < 85)
					p = $urandom_range(planned_len - 1);
				queue_cmd(k, p, v);
				if (filling && full_hits >= 3) begin
					filling = 1'b0;
					full_hits = 0;
				end else if (!filling && planned_len <= 2) begin
					filling = 1'b1;
				end
			end
			// hold the sender until every result of this pattern is back
			while (queued_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
		end

		repeat (20) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
